>>> rtl/core/ple_pkg.sv
// Shared constants, codes and controller/datapath handshake types for the
// positional list engine. No dependencies.

package ple_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam int CMD_W  = 2;
  localparam int POS_W  = 6;
  localparam int DATA_W = 32;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 6;
  localparam int WORD_W = 40;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic take;   // latch the input word
    logic exec;   // evaluate the latched command
    logic step;   // emit one dump entry and rotate
  } ple_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;   // output register can load this cycle
    logic dump_go;    // latched command is a dump of a non-empty list
    logic dump_last;  // next dump entry is the final one
  } ple_stat_t;

endpackage

>>> rtl/core/ple_ctrl.sv
// Controller state machine of the positional list engine.
// Depends on ple_pkg for the command and status structs.

module ple_ctrl
  import ple_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  ple_stat_t stat,
  output ple_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DUMP = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.out_free) state_next = stat.dump_go ? S_DUMP : S_IDLE;
      end
      S_DUMP: begin
        if (stat.out_free && stat.dump_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign s_tready = (state == S_IDLE);
  assign cmd.take = s_tvalid && (state == S_IDLE);
  assign cmd.exec = (state == S_EXEC);
  assign cmd.step = (state == S_DUMP);

endmodule

>>> rtl/core/ple_datapath.sv
// Datapath of the positional list engine: shifting entry chain, length,
// latched input word and the output register.
// Depends on ple_pkg for widths, codes and the command and status structs.

module ple_datapath
  import ple_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ple_cmd_t                 cmd,
  output ple_stat_t                stat,
  input  logic [CMD_W-1:0]         in_command,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ST_W-1:0]          out_status,
  output logic [CNT_W-1:0]         out_count,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_last
);

  localparam int LW = $clog2(CAPACITY + 1);
  // compare width wide enough for both a position and length+1
  localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

  logic [CMD_W-1:0]         item_cmd;
  logic [POS_W-1:0]         item_pos;
  logic signed [DATA_W-1:0] item_val;

  logic signed [DATA_W-1:0] entries [CAPACITY];
  logic [LW-1:0]            length, length_next;
  logic [LW-1:0]            dcnt;

  logic [CW-1:0] pos_x, pos0, len_x;
  logic          ins_pos_ok, del_pos_ok, full;
  logic          do_ins, do_del, dump_go, dump_last;
  logic [ST_W-1:0] res_status;
  logic          out_free, emit_single, ins_en, del_en, step_en;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_cmd <= in_command;
      item_pos <= in_position;
      item_val <= in_value;
    end
  end

  assign pos_x      = CW'(item_pos);
  assign pos0       = pos_x - CW'(1);
  assign len_x      = CW'(length);
  assign ins_pos_ok = (pos_x != '0) && (pos_x <= len_x + CW'(1));
  assign del_pos_ok = (pos_x != '0) && (pos_x <= len_x);
  assign full       = (length == LW'(CAPACITY));

  always_comb begin
    res_status = ST_INVALID;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    dump_go    = 1'b0;
    case (item_cmd)
      CMD_INSERT: begin
        if (!ins_pos_ok) begin
          res_status = ST_INVALID;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          res_status = ST_OK;
          do_ins     = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (del_pos_ok) begin
          res_status = ST_OK;
          do_del     = 1'b1;
        end
      end
      CMD_DUMP: begin
        if (length == '0) begin
          res_status = ST_EMPTY;
        end else begin
          res_status = ST_OK;
          dump_go    = 1'b1;
        end
      end
      default: res_status = ST_INVALID;
    endcase
  end

  assign dump_last   = (dcnt == length - LW'(1));
  assign out_free    = !out_valid || out_ready;
  assign emit_single = cmd.exec && out_free && !dump_go;
  assign ins_en      = emit_single && do_ins;
  assign del_en      = emit_single && do_del;
  assign step_en     = cmd.step && out_free;

  assign stat.out_free  = out_free;
  assign stat.dump_go   = dump_go;
  assign stat.dump_last = dump_last;

  always_comb begin
    length_next = length;
    if (ins_en) length_next = length + LW'(1);
    else if (del_en) length_next = length - LW'(1);
  end

  // Entry chain: each cell picks from its neighbors. A dump rotates the
  // valid part left by one per word, so after length steps it is restored.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev, nxt;
    if (i == 0) begin : g_first
      assign prev = item_val;
    end else begin : g_mid
      assign prev = entries[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign nxt = entries[i];
    end else begin : g_inner
      assign nxt = entries[i+1];
    end

    always_ff @(posedge clk) begin
      if (ins_en) begin
        if (CW'(i) > pos0) entries[i] <= prev;
        else if (CW'(i) == pos0) entries[i] <= item_val;
      end else if (del_en) begin
        if (CW'(i) >= pos0) entries[i] <= nxt;
      end else if (step_en) begin
        entries[i] <= (CW'(i) == len_x - CW'(1)) ? entries[0] : nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
      dcnt   <= '0;
    end else begin
      length <= length_next;
      if (step_en) dcnt <= dump_last ? '0 : dcnt + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_single || step_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_single) begin
      out_status <= res_status;
      out_count  <= CNT_W'(length_next);
      out_value  <= '0;
      out_last   <= 1'b1;
    end else if (step_en) begin
      out_status <= ST_OK;
      out_count  <= CNT_W'(length);
      out_value  <= entries[0];
      out_last   <= dump_last;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= LW'(CAPACITY))
    else $error("list length above capacity");

  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status != ST_OK) |-> out_value == '0)
    else $error("nonzero value on a status word");

  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    ins_en |=> length == $past(length) + LW'(1))
    else $error("insert did not grow the list");

  a_dump_nonempty: assert property (@(posedge clk) disable iff (rst)
    step_en |-> length != '0)
    else $error("dump step on an empty list");

endmodule

>>> rtl/core/positional_list_engine.sv
// Positional list engine: ordered list of signed 32-bit values with insert,
// delete and dump at one-based positions.
// Each accepted word is latched and then evaluated in the exec state; a single
// result word loads into the output register from there once it is free. A dump
// emits one entry per cycle while the output register is free, rotated out of
// the chain. No new word is accepted until the result or last entry has loaded.
// Reset clears the length, dump counter, controller and output valid; entries are unset.

module positional_list_engine
  import ple_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [WORD_W-1:0] s_tdata,   // command[1:0], position[7:2], value_in[39:8]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [WORD_W-1:0] m_tdata,   // status[1:0], entry_count[7:2], value_out[39:8]
  output logic              m_tlast
);

  ple_cmd_t  cmd;
  ple_stat_t stat;

  logic [ST_W-1:0]          out_status;
  logic [CNT_W-1:0]         out_count;
  logic signed [DATA_W-1:0] out_value;

  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ple_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_command  (s_tdata[1:0]),
    .in_position (s_tdata[7:2]),
    .in_value    (s_tdata[39:8]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_status  (out_status),
    .out_count   (out_count),
    .out_value   (out_value),
    .out_last    (m_tlast)
  );

  assign m_tdata = {out_value, out_count, out_status};

endmodule

>>> test/positional_list_engine_tb.sv
// Testbench for positional_list_engine: directed and random insert, delete and
// dump commands over the stream ports, checked against an in-bench list model.
// Depends on ple_pkg and the positional_list_engine RTL.
`timescale 1ns / 1ps

module positional_list_engine_tb;
  import ple_pkg::*;

  localparam int LIST_CAP = CAPACITY_DEF;
  localparam int HOLD_CYCLES = 150;
  localparam int STALL_LIMIT = 2000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [ST_W-1:0]   status;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] value;
    logic              last;
  } list_result_t;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [WORD_W-1:0] s_tdata = '0;  // command[1:0], position[7:2], value_in[39:8]
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [WORD_W-1:0] m_tdata;       // status[1:0], entry_count[7:2], value_out[39:8]
  logic m_tlast;

  // list model: contents and length as seen after every accepted word
  logic [DATA_W-1:0] list_mem [LIST_CAP];
  int list_len = 0;
  list_result_t pending_results[$];
  list_result_t want;

  int mismatch_count = 0;
  int quiet_cycles = 0;
  bit idle_en = 1'b1;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  positional_list_engine uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic push_result(input logic [ST_W-1:0] status, input logic [DATA_W-1:0] value,
                             input logic last);
    list_result_t r;
    r.status = status;
    r.count = list_len[CNT_W-1:0];
    r.value = value;
    r.last = last;
    pending_results.push_back(r);
  endtask

  task automatic apply_list_op(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                               input logic [DATA_W-1:0] val);
    int i;
    int p;
    p = int'(pos);
    case (cmd)
      CMD_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          push_result(ST_INVALID, '0, 1'b1);
        end else if (list_len >= LIST_CAP) begin
          push_result(ST_FULL, '0, 1'b1);
        end else begin
          for (i = list_len; i > p - 1; i--) list_mem[i] = list_mem[i-1];
          list_mem[p-1] = val;
          list_len++;
          push_result(ST_OK, '0, 1'b1);
        end
      end
      CMD_DELETE: begin
        if (p < 1 || p > list_len) begin
          push_result(ST_INVALID, '0, 1'b1);
        end else begin
          for (i = p - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
          push_result(ST_OK, '0, 1'b1);
        end
      end
      CMD_DUMP: begin
        if (list_len == 0) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < list_len; i++) push_result(ST_OK, list_mem[i], i + 1 == list_len);
        end
      end
      default: push_result(ST_INVALID, '0, 1'b1);
    endcase
  endtask

  // offer one word, hold it until accepted, then update the model
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                           input logic [DATA_W-1:0] val);
    if (idle_en && $urandom_range(0, 99) < 16) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {val, pos, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_list_op(cmd, pos, val);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_empty_list;
    send_word(CMD_DUMP, 6'd0, 32'h0);
    send_word(CMD_DELETE, 6'd1, 32'h0);
    send_word(CMD_DELETE, 6'd0, 32'h0);
    send_word(CMD_INSERT, 6'd0, 32'h1234_5678);
    send_word(CMD_INSERT, 6'd2, 32'h1234_5678);
    send_word(CMD_UNUSED, 6'd0, 32'hFFFF_FFFF);
  endtask

  task automatic test_ends_and_middle;
    send_word(CMD_INSERT, 6'd1, 32'h7FFF_FFFF);
    send_word(CMD_INSERT, 6'd2, 32'h8000_0000);
    send_word(CMD_INSERT, 6'd1, 32'hFFFF_FFFF);
    send_word(CMD_INSERT, 6'd2, 32'h0000_0000);
    send_word(CMD_INSERT, 6'd3, 32'hA5A5_5A5A);
    send_word(CMD_DUMP, 6'd63, 32'h0);
    send_word(CMD_DELETE, 6'd6, 32'h0);
    send_word(CMD_DELETE, 6'd5, 32'h0);
    send_word(CMD_DELETE, 6'd1, 32'h0);
    send_word(CMD_DELETE, 6'd2, 32'h0);
    send_word(CMD_INSERT, 6'd63, 32'h5555_AAAA);
    send_word(CMD_UNUSED, 6'd63, 32'h0);
    send_word(CMD_DUMP, 6'd0, 32'h0);
    drain();
  endtask

  task automatic test_full_list;
    while (list_len < LIST_CAP)
      send_word(CMD_INSERT, POS_W'($urandom_range(1, list_len + 1)), $urandom);
    send_word(CMD_INSERT, 6'd33, 32'hDEAD_BEEF);
    send_word(CMD_INSERT, 6'd34, 32'hDEAD_BEEF);
    send_word(CMD_INSERT, 6'd1, 32'hDEAD_BEEF);
    send_word(CMD_DUMP, 6'd0, 32'h0);
    send_word(CMD_DELETE, 6'd33, 32'h0);
    send_word(CMD_DELETE, 6'd32, 32'h0);
    send_word(CMD_DELETE, 6'd1, 32'h0);
    drain();
  endtask

  // stall the output while words keep coming, so the block backs up
  task automatic test_backpressure;
    hold_req = 1'b1;
    send_word(CMD_DUMP, 6'd0, 32'h0);
    repeat (12) begin
      send_word(CMD_DELETE, POS_W'($urandom_range(1, list_len)), 32'h0);
      send_word(CMD_INSERT, POS_W'($urandom_range(1, list_len + 1)), $urandom);
    end
    send_word(CMD_DUMP, 6'd0, 32'h0);
    drain();
  endtask

  // grow toward full, then shrink toward empty, with some noise and dumps
  task automatic random_ops(input int n);
    bit growing;
    int pick;
    growing = 1'b1;
    repeat (n) begin
      if (list_len >= LIST_CAP) growing = 1'b0;
      if (list_len == 0) growing = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_word(CMD_W'($urandom_range(0, 3)), POS_W'($urandom_range(0, 63)), $urandom);
      end else if (pick < 18) begin
        send_word(CMD_DUMP, POS_W'($urandom_range(0, 63)), $urandom);
      end else if ((pick < 66) == growing) begin
        send_word(CMD_INSERT, POS_W'($urandom_range(1, list_len + 1)), $urandom);
      end else begin
        send_word(CMD_DELETE, POS_W'((list_len == 0) ? 1 : $urandom_range(1, list_len)),
                  $urandom);
      end
    end
  endtask

  task automatic test_random_mix;
    idle_en = 1'b1;
    random_ops(120);
  endtask

  task automatic test_steady_stream;
    idle_en = 1'b0;
    random_ops(60);
    idle_en = 1'b1;
  endtask

  // output side: random idling, or a counted hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        m_tready <= !(idle_en && $urandom_range(0, 99) < 16);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word status %0d count %0d value %h last %b", $time,
                 m_tdata[1:0], m_tdata[7:2], m_tdata[39:8], m_tlast);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[1:0] !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_tdata[1:0]);
          mismatch_count++;
        end
        if (m_tdata[7:2] !== want.count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.count, m_tdata[7:2]);
          mismatch_count++;
        end
        if (m_tdata[39:8] !== want.value) begin
          $display("%0t: value_out expected %h actual %h", $time, want.value, m_tdata[39:8]);
          mismatch_count++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, m_tlast);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_ends_and_middle();
    test_full_list();
    test_backpressure();
    test_random_mix();
    test_steady_stream();
    drain();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
